// File: rtl/tea_pkg.sv
// ----------------------------------------------------------------------------
// tea_pkg
// Types, constants and the round mixing function shared by the block cipher.
// ----------------------------------------------------------------------------
package tea_pkg;

    localparam int          TEA_ROUNDS   = 16;
    localparam int          TEA_WORD_W   = 32;
    localparam int          TEA_CFG_IDX_W = 3;
    localparam logic [31:0] TEA_DELTA    = 32'h9E37_79B9;

    // configuration register indexes
    localparam logic [TEA_CFG_IDX_W-1:0] CFG_KEY_WORD_0 = 3'd0;
    localparam logic [TEA_CFG_IDX_W-1:0] CFG_KEY_WORD_1 = 3'd1;
    localparam logic [TEA_CFG_IDX_W-1:0] CFG_KEY_WORD_2 = 3'd2;
    localparam logic [TEA_CFG_IDX_W-1:0] CFG_KEY_WORD_3 = 3'd3;

    // opcodes
    localparam logic OP_ENCRYPT = 1'b0;
    localparam logic OP_DECRYPT = 1'b1;

    typedef struct packed {
        logic        opcode;
        logic [31:0] left;
        logic [31:0] right;
    } t_tea_data;

    typedef struct packed {
        logic [31:0] k0;
        logic [31:0] k1;
        logic [31:0] k2;
        logic [31:0] k3;
    } t_tea_key;

    function automatic logic [31:0] tea_mix(
        input logic [31:0] x,
        input logic [31:0] sum,
        input logic [31:0] ka,
        input logic [31:0] kb
    );
        tea_mix = ((x << 4) + ka) ^ (x + sum) ^ ((x >> 5) + kb);
    endfunction

endpackage

// File: rtl/tea_cell.sv
// ----------------------------------------------------------------------------
// tea_cell
// One half round of the cipher: updates one block word and hands the block
// to the next cell, with a local valid bit and a ready chain for stalls.
// ----------------------------------------------------------------------------
module tea_cell #(
    parameter int ROUNDS = tea_pkg::TEA_ROUNDS,
    parameter int STAGE  = 0
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  tea_pkg::t_tea_key  i_key,
    input  logic               i_valid,
    input  tea_pkg::t_tea_data i_data,
    output logic               o_ready,
    output logic               o_valid,
    output tea_pkg::t_tea_data o_data,
    input  logic               i_ready
);
    import tea_pkg::*;

    localparam int          ROUND    = STAGE / 2;
    localparam bit          HALF     = (STAGE % 2) != 0;
    localparam logic [63:0] ENC_PROD = 64'(ROUND + 1) * 64'(TEA_DELTA);
    localparam logic [63:0] DEC_PROD = 64'(ROUNDS - ROUND) * 64'(TEA_DELTA);
    localparam logic [31:0] ENC_SUM  = ENC_PROD[31:0];
    localparam logic [31:0] DEC_SUM  = DEC_PROD[31:0];

    logic        r_valid;
    t_tea_data   r_data;
    t_tea_data   n_data;
    logic        upd_left;
    logic [31:0] src;
    logic [31:0] dst;
    logic [31:0] sum;
    logic [31:0] ka;
    logic [31:0] kb;
    logic [31:0] mixed;
    logic [31:0] res;

    // encrypt first half and decrypt second half work on the left word
    always_comb begin
        upd_left = (!HALF) ^ (i_data.opcode == OP_DECRYPT);
        src      = upd_left ? i_data.right : i_data.left;
        dst      = upd_left ? i_data.left  : i_data.right;
        ka       = upd_left ? i_key.k0 : i_key.k2;
        kb       = upd_left ? i_key.k1 : i_key.k3;
        sum      = (i_data.opcode == OP_DECRYPT) ? DEC_SUM : ENC_SUM;
        mixed    = tea_mix(src, sum, ka, kb);
        res      = (i_data.opcode == OP_DECRYPT) ? (dst - mixed) : (dst + mixed);
        n_data   = i_data;
        if (upd_left) begin
            n_data.left = res;
        end else begin
            n_data.right = res;
        end
    end

    assign o_ready = !r_valid || i_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_data <= n_data;
        end
    end

    assign o_valid = r_valid;
    assign o_data  = r_data;

endmodule

// File: rtl/tea_block_cipher.sv
// ----------------------------------------------------------------------------
// tea_block_cipher
// Pipelined TEA encryption and decryption of 64-bit blocks.
// ----------------------------------------------------------------------------
// Input channel: i_in_valid / o_in_stall carry a request of opcode (0 encrypt,
// 1 decrypt) and the two block words. Output channel: o_out_valid /
// i_out_stall carry the resulting two words. A request moves when valid is
// high and stall is low.
// The key is four 32-bit words written through i_cfg_we / i_cfg_index /
// i_cfg_data; indexes above three are ignored. Write the key only while the
// pipeline is empty.
// The datapath is a chain of 2*ROUNDS half-round cells, one register each,
// and one block is taken per cycle while o_in_stall is low. Every cell has
// a valid bit; a stalled receiver holds the last cell, and the stall walks
// back only through occupied cells, so empty slots still fill. o_in_stall
// rises only when all cells are full and the output is stalled.
// Reset clears all valid bits and sets the key words to zero.
// ----------------------------------------------------------------------------
module tea_block_cipher #(
    parameter int ROUNDS = tea_pkg::TEA_ROUNDS
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_cfg_we,
    input  logic [tea_pkg::TEA_CFG_IDX_W-1:0] i_cfg_index,
    input  logic [tea_pkg::TEA_WORD_W-1:0]    i_cfg_data,
    input  logic                              i_in_valid,
    output logic                              o_in_stall,
    input  logic                              i_opcode,
    input  logic [tea_pkg::TEA_WORD_W-1:0]    i_block_left,
    input  logic [tea_pkg::TEA_WORD_W-1:0]    i_block_right,
    output logic                              o_out_valid,
    input  logic                              i_out_stall,
    output logic [tea_pkg::TEA_WORD_W-1:0]    o_out_left,
    output logic [tea_pkg::TEA_WORD_W-1:0]    o_out_right
);
    import tea_pkg::*;

    localparam int CELLS = 2 * ROUNDS;

    t_tea_key  r_key;
    logic      w_valid [0:CELLS];
    logic      w_ready [0:CELLS];
    t_tea_data w_data  [0:CELLS];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_key <= '0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                CFG_KEY_WORD_0: r_key.k0 <= i_cfg_data;
                CFG_KEY_WORD_1: r_key.k1 <= i_cfg_data;
                CFG_KEY_WORD_2: r_key.k2 <= i_cfg_data;
                CFG_KEY_WORD_3: r_key.k3 <= i_cfg_data;
                default: ;
            endcase
        end
    end

    assign w_valid[0]        = i_in_valid;
    assign w_data[0].opcode  = i_opcode;
    assign w_data[0].left    = i_block_left;
    assign w_data[0].right   = i_block_right;
    assign w_ready[CELLS]    = !i_out_stall;

    for (genvar k = 0; k < CELLS; k++) begin : g_cell
        tea_cell #(
            .ROUNDS (ROUNDS),
            .STAGE  (k)
        ) u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_key   (r_key),
            .i_valid (w_valid[k]),
            .i_data  (w_data[k]),
            .o_ready (w_ready[k]),
            .o_valid (w_valid[k+1]),
            .o_data  (w_data[k+1]),
            .i_ready (w_ready[k+1])
        );
    end

    assign o_in_stall  = !w_ready[0];
    assign o_out_valid = w_valid[CELLS];
    assign o_out_left  = w_data[CELLS].left;
    assign o_out_right = w_data[CELLS].right;

`ifndef SYNTHESIS
    // an accepted request always lands in the first cell
    a_accept_enters: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && !o_in_stall) |=> w_valid[1])
        else $error("accepted request did not enter first cell");

    // input stalls only when a result waits at a stalled output
    a_stall_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_stall |-> (o_out_valid && i_out_stall && w_valid[1]))
        else $error("input stalled without a full, stalled pipeline");

    // a delivered result frees the last cell unless the chain refills it
    a_drain: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !i_out_stall && !w_valid[CELLS-1]) |=> !o_out_valid)
        else $error("delivered result repeated at output");
`endif

endmodule
